>>> rtl/glg_pkg.sv
package glg_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DIM_W    = 7;
  localparam int CNT_W    = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int GEN_W    = 16;
  localparam int NB_W     = 4;

  localparam logic [NB_W-1:0] BIRTH_COUNT = NB_W'(3);
  localparam logic [NB_W-1:0] SURVIVE_LOW = NB_W'(2);
  localparam logic [CNT_W-1:0] CELL_TOTAL = CNT_W'(MAX_ROWS * MAX_COLS);

  typedef logic [MAX_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_RUN   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STOP_LIMIT  = 2'd0,
    STOP_DIE    = 2'd1,
    STOP_STABLE = 2'd2
  } stop_t;

  typedef enum logic {
    CFG_GRID_ROWS = 1'b0,
    CFG_GRID_COLS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic cur;
    logic nxt;
  } cell_eval_t;

  function automatic logic [ROW_W-1:0] last_row_of(logic [DIM_W-1:0] v);
    if (v == '0) return '0;
    if (32'(v) > MAX_ROWS) return ROW_W'(MAX_ROWS - 1);
    return ROW_W'(v - 1'b1);
  endfunction

  function automatic logic [COL_W-1:0] last_col_of(logic [DIM_W-1:0] v);
    if (v == '0) return '0;
    if (32'(v) > MAX_COLS) return COL_W'(MAX_COLS - 1);
    return COL_W'(v - 1'b1);
  endfunction

endpackage

>>> rtl/life_grid_generation_engine_top.sv
// Toroidal Life engine. An item is taken when start is high and busy is low;
// its single result appears for one cycle with done high and cannot be held
// off. A cell write or read goes through S_ACC and then S_DONE. For each
// generation a run evaluates, each row is fetched with its two neighbors
// through the single read port of the grid memory, then one cell per cycle
// goes through the neighbor counter, and a committed generation is copied
// back one row per cycle. A write to grid_rows or grid_cols recounts the
// live cells over the new window, which holds busy high until that sweep
// ends. The grid reads as all dead after reset at once, without a clearing
// pass.
module life_grid_generation_engine_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode,
  input  logic [glg_pkg::ROW_W-1:0]   row,
  input  logic [glg_pkg::COL_W-1:0]   col,
  input  logic                        alive_in,
  input  logic [glg_pkg::GEN_W-1:0]   gen_limit,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [glg_pkg::DIM_W-1:0]   cfg_wdata,
  output logic                        done,
  output logic                        cell_alive,
  output logic [glg_pkg::CNT_W-1:0]   alive_count,
  output logic [glg_pkg::GEN_W-1:0]   gens_done,
  output logic [1:0]                  stop_cause
);
  import glg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_RUN_CHK,
    S_RD_UP,
    S_RD_MID,
    S_RD_DN,
    S_RD_CAP,
    S_CELLS,
    S_ROW_WR,
    S_SWEEP_END,
    S_COPY,
    S_COPY_LAST,
    S_DONE
  } state_t;

  state_t           state;
  logic [DIM_W-1:0] grid_rows;
  logic [DIM_W-1:0] grid_cols;
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] last_col;

  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] r_up;
  logic [ROW_W-1:0] r_dn;
  logic             sweep_run;
  row_t             up_row;
  row_t             mid_row;
  row_t             dn_row;
  row_t             next_row;
  logic [CNT_W-1:0] sweep_cnt;
  logic             changed;
  logic [GEN_W-1:0] gens;
  logic [GEN_W-1:0] limit;
  logic             copy_wv;
  logic [ROW_W-1:0] copy_wa;

  logic [1:0]       item_mode;
  logic [ROW_W-1:0] item_row;
  logic [COL_W-1:0] item_col;
  logic             item_alive;
  logic             item_inside;
  logic             res_cell;
  stop_t            res_cause;
  logic [CNT_W-1:0] live_total;

  logic [MAX_ROWS-1:0] row_valid;
  logic                valid_q;

  logic [ROW_W-1:0] now_raddr;
  logic [ROW_W-1:0] now_waddr;
  logic             now_we;
  row_t             now_wdata;
  row_t             now_rdata;
  row_t             rdm;
  row_t             patched;
  logic             item_we;
  logic             next_we;
  row_t             next_rdata;
  cell_eval_t       eval;

  assign last_row = last_row_of(grid_rows);
  assign last_col = last_col_of(grid_cols);
  assign busy     = (state != S_IDLE) || cfg_wr_en;
  assign r_up     = (r == '0) ? last_row : r - 1'b1;
  assign r_dn     = (r == last_row) ? '0 : r + 1'b1;
  assign rdm      = valid_q ? now_rdata : '0;

  always_comb begin
    patched           = rdm;
    patched[item_col] = item_alive;
  end

  always_comb begin
    unique case (state)
      S_IDLE:  now_raddr = row;
      S_RD_UP: now_raddr = r_up;
      S_RD_DN: now_raddr = r_dn;
      default: now_raddr = r;
    endcase
  end

  assign item_we   = (state == S_ACC) && (item_mode == MODE_WRITE) && item_inside;
  assign now_we    = copy_wv || item_we;
  assign now_waddr = copy_wv ? copy_wa : item_row;
  assign now_wdata = copy_wv ? next_rdata : patched;
  assign next_we   = (state == S_ROW_WR) && sweep_run;

  glg_ram #(.DEPTH(MAX_ROWS), .WIDTH(MAX_COLS)) u_now_mem (
    .clk   (clk),
    .we    (now_we),
    .waddr (now_waddr),
    .wdata (now_wdata),
    .raddr (now_raddr),
    .rdata (now_rdata)
  );

  glg_ram #(.DEPTH(MAX_ROWS), .WIDTH(MAX_COLS)) u_next_mem (
    .clk   (clk),
    .we    (next_we),
    .waddr (r),
    .wdata (next_row),
    .raddr (r),
    .rdata (next_rdata)
  );

  glg_cell_unit u_cell (
    .up       (up_row),
    .mid      (mid_row),
    .dn       (dn_row),
    .col      (c),
    .last_col (last_col),
    .eval     (eval)
  );

  always_ff @(posedge clk) begin
    valid_q <= row_valid[now_raddr];
    copy_wa <= r;
    if (rst) begin
      row_valid <= '0;
    end else if (now_we) begin
      row_valid[now_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      grid_rows  <= DIM_W'(MAX_ROWS);
      grid_cols  <= DIM_W'(MAX_COLS);
      live_total <= '0;
      copy_wv    <= 1'b0;
      done       <= 1'b0;
      sweep_run  <= 1'b0;
      sweep_cnt  <= '0;
    end else begin
      copy_wv <= (state == S_COPY);
      done    <= (state == S_DONE);
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_GRID_ROWS: grid_rows <= cfg_wdata;
          CFG_GRID_COLS: grid_cols <= cfg_wdata;
          default: ;
        endcase
        r         <= '0;
        sweep_run <= 1'b0;
        sweep_cnt <= '0;
        changed   <= 1'b0;
        state     <= S_RD_UP;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (start) begin
              item_mode   <= mode;
              item_row    <= row;
              item_col    <= col;
              item_alive  <= alive_in;
              item_inside <= (row <= last_row) && (col <= last_col);
              limit       <= gen_limit;
              gens        <= '0;
              res_cell    <= 1'b0;
              res_cause   <= STOP_LIMIT;
              state       <= (mode == MODE_RUN) ? S_RUN_CHK : S_ACC;
            end
          end
          S_ACC: begin
            case (item_mode)
              MODE_READ: res_cell <= item_inside & rdm[item_col];
              MODE_WRITE: begin
                if (item_we && (rdm[item_col] != item_alive)) begin
                  live_total <= item_alive ? live_total + 1'b1 : live_total - 1'b1;
                end
              end
              default: ;
            endcase
            state <= S_DONE;
          end
          S_RUN_CHK: begin
            if (gens == limit) begin
              state <= S_DONE;
            end else begin
              r         <= '0;
              sweep_run <= 1'b1;
              sweep_cnt <= '0;
              changed   <= 1'b0;
              state     <= S_RD_UP;
            end
          end
          S_RD_UP: state <= S_RD_MID;
          S_RD_MID: begin
            up_row <= rdm;
            state  <= S_RD_DN;
          end
          S_RD_DN: begin
            mid_row <= rdm;
            state   <= S_RD_CAP;
          end
          S_RD_CAP: begin
            dn_row   <= rdm;
            next_row <= mid_row;
            c        <= '0;
            state    <= S_CELLS;
          end
          S_CELLS: begin
            next_row[c] <= eval.nxt;
            sweep_cnt   <= sweep_cnt + CNT_W'(sweep_run ? eval.nxt : eval.cur);
            changed     <= changed | (eval.nxt ^ eval.cur);
            if (c == last_col) begin
              state <= S_ROW_WR;
            end else begin
              c <= c + 1'b1;
            end
          end
          S_ROW_WR: begin
            if (r == last_row) begin
              state <= S_SWEEP_END;
            end else begin
              r     <= r + 1'b1;
              state <= S_RD_UP;
            end
          end
          S_SWEEP_END: begin
            if (!sweep_run) begin
              live_total <= sweep_cnt;
              state      <= S_IDLE;
            end else if (sweep_cnt == '0) begin
              res_cause <= STOP_DIE;
              state     <= S_DONE;
            end else if (!changed) begin
              res_cause <= STOP_STABLE;
              state     <= S_DONE;
            end else begin
              r     <= '0;
              state <= S_COPY;
            end
          end
          S_COPY: begin
            if (r == last_row) begin
              state <= S_COPY_LAST;
            end else begin
              r <= r + 1'b1;
            end
          end
          S_COPY_LAST: begin
            gens       <= gens + 1'b1;
            live_total <= sweep_cnt;
            state      <= S_RUN_CHK;
          end
          S_DONE: begin
            cell_alive  <= res_cell;
            alive_count <= live_total;
            gens_done   <= gens;
            stop_cause  <= res_cause;
            state       <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held for two cycles");

  a_copy_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !copy_wv) else $error("row copy still writing when idle");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (done && cell_alive) |-> (gens_done == '0) && (stop_cause == STOP_LIMIT))
    else $error("read result carries run status");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (live_total <= CELL_TOTAL) && (sweep_cnt <= CELL_TOTAL || !busy))
    else $error("live count beyond grid size");

  a_commit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY_LAST) |-> (sweep_cnt != '0) && changed)
    else $error("committing an empty or unchanged generation");

endmodule

>>> rtl/glg_ram.sv
module glg_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/glg_cell_unit.sv
module glg_cell_unit (
  input  glg_pkg::row_t              up,
  input  glg_pkg::row_t              mid,
  input  glg_pkg::row_t              dn,
  input  logic [glg_pkg::COL_W-1:0]  col,
  input  logic [glg_pkg::COL_W-1:0]  last_col,
  output glg_pkg::cell_eval_t        eval
);
  import glg_pkg::*;

  logic [COL_W-1:0] cm;
  logic [COL_W-1:0] cp;
  logic [NB_W-1:0]  nb;

  always_comb begin
    cm = (col == '0) ? last_col : col - 1'b1;
    cp = (col == last_col) ? '0 : col + 1'b1;
    nb = NB_W'(up[cm]) + NB_W'(up[col]) + NB_W'(up[cp])
       + NB_W'(mid[cm]) + NB_W'(mid[cp])
       + NB_W'(dn[cm]) + NB_W'(dn[col]) + NB_W'(dn[cp]);
    eval.cur = mid[col];
    if (mid[col]) begin
      eval.nxt = (nb == SURVIVE_LOW) || (nb == BIRTH_COUNT);
    end else begin
      eval.nxt = (nb == BIRTH_COUNT);
    end
  end

endmodule
